[hw/rtl/emboss_pkg.sv]
// ----------------------------------------------------------------------------
// emboss_pkg
// Shared types and constants of the streaming 3x3 emboss filter.
// ----------------------------------------------------------------------------
package emboss_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MIN_DIM    = 3;

  localparam int PIX_W  = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = 10;
  localparam int CFG_W  = 10;
  localparam int IDX_W  = 2;
  localparam int SUM_W  = 12;

  localparam int BIAS    = 128;
  localparam int PIX_MAX = 255;

  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_LVL_W = 2;

  localparam logic [IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } result_t;

  typedef struct packed {
    logic                  push;
    result_t               data;
  } fifo_push_t;

endpackage

[hw/rtl/emboss_if.sv]
// ----------------------------------------------------------------------------
// emboss channel interfaces
// Valid/ready channels for pixels in, embossed results out and register writes.
// ----------------------------------------------------------------------------
interface emboss_in_if;
  logic                            valid;
  logic                            ready;
  logic [emboss_pkg::PIX_W-1:0]    pixel;
  logic                            frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface emboss_out_if;
  logic                            valid;
  logic                            ready;
  logic [emboss_pkg::PIX_W-1:0]    value;
  logic [emboss_pkg::ROW_W-1:0]    out_row;
  logic [emboss_pkg::COL_W-1:0]    out_col;
  logic                            frame_last;

  modport source (output valid, output value, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input value, input out_row, input out_col,
                input frame_last, output ready);
endinterface

interface emboss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [emboss_pkg::IDX_W-1:0]    index;
  logic [emboss_pkg::CFG_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/emboss_ram.sv]
// ----------------------------------------------------------------------------
// emboss_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module emboss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/emboss_out_fifo.sv]
// ----------------------------------------------------------------------------
// emboss_out_fifo
// Three-entry result queue that drives the output channel.
// ----------------------------------------------------------------------------
module emboss_out_fifo (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  emboss_pkg::fifo_push_t               push,
  output logic [emboss_pkg::FIFO_LVL_W-1:0]    level,
  emboss_out_if.source                         out_stream
);

  emboss_pkg::result_t                     slot_r [emboss_pkg::FIFO_DEPTH];
  logic [emboss_pkg::FIFO_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [emboss_pkg::FIFO_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [emboss_pkg::FIFO_LVL_W-1:0]       level_r, level_nxt;
  logic                                    pop;
  emboss_pkg::result_t                     head;

  function automatic logic [emboss_pkg::FIFO_PTR_W-1:0] ptr_inc(
    input logic [emboss_pkg::FIFO_PTR_W-1:0] p
  );
    if (p == emboss_pkg::FIFO_PTR_W'(emboss_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign pop  = (level_r != '0) && out_stream.ready;
  assign head = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push.push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    level_nxt  = level_r;
    if (push.push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push.push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      slot_r[wr_ptr_r] <= push.data;
    end
  end

  assign level                 = level_r;
  assign out_stream.valid      = (level_r != '0);
  assign out_stream.value      = head.value;
  assign out_stream.out_row    = head.row;
  assign out_stream.out_col    = head.col;
  assign out_stream.frame_last = head.last;

endmodule

[hw/rtl/emboss_3x3_filter.sv]
// ----------------------------------------------------------------------------
// emboss_3x3_filter
// Streaming 3x3 emboss convolution over 8-bit pixels in raster order, with the
// two previous rows held in one line-store RAM.
//
//   Channel     Dir   Moves per transfer
//   in_stream   in    one pixel and its frame-start flag
//   out_stream  out   one embossed interior pixel with row, column, last mark
//   cfg_bus     in    one register write (image width or image height)
//
// One pixel is taken every cycle while the result queue has room. A result
// passes the stage-1 registers, then the queue, after the transfer of the
// pixel that completes its window. The line-store RAM is read when a pixel
// is taken and written back in the next cycle. Reset needs no clearing pass.
// A consumer stall fills the queue and input transfers stop until it has room.
// ----------------------------------------------------------------------------
module emboss_3x3_filter (
  input  logic          clk,
  input  logic          rst_n,
  emboss_in_if.sink     in_stream,
  emboss_out_if.source  out_stream,
  emboss_cfg_if.sink    cfg_bus
);

  localparam int PW = emboss_pkg::PIX_W;
  localparam int CW = emboss_pkg::COL_W;
  localparam int RW = emboss_pkg::ROW_W;
  localparam int DW = emboss_pkg::DIM_W;
  localparam int SW = emboss_pkg::SUM_W;

  logic [DW-1:0] width_r, height_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  logic          in_xfer;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [DW-1:0] col_inc, row_inc;
  logic          col_wrap;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;

  logic          s1_valid_r;
  logic [PW-1:0] s1_px_r;
  logic [CW-1:0] s1_addr_r;
  logic          s1_emit_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_last_r;
  logic          s1_fwd_r;
  logic [PW-1:0] fwd_upper_r, fwd_middle_r;

  logic [2*PW-1:0] ram_rdata;
  logic [PW-1:0]   s1_top, s1_mid;

  logic [PW-1:0] w00_r, w01_r, w10_r, w11_r, w21_r;

  logic signed [SW-1:0] sum;
  logic [PW-1:0]        value;

  emboss_pkg::fifo_push_t              fifo_push;
  logic [emboss_pkg::FIFO_LVL_W-1:0]   fifo_level;
  logic [emboss_pkg::FIFO_LVL_W:0]     occupancy;

  // Register writes.
  assign cfg_bus.ready = 1'b1;

  function automatic logic [DW-1:0] clamp_dim(input logic [emboss_pkg::CFG_W-1:0] v,
                                              input int hi);
    if (int'(v) < emboss_pkg::MIN_DIM) begin
      return DW'(emboss_pkg::MIN_DIM);
    end
    if (int'(v) > hi) begin
      return DW'(hi);
    end
    return DW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(emboss_pkg::MAX_WIDTH);
      height_r <= DW'(emboss_pkg::MAX_HEIGHT);
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        emboss_pkg::CFG_IDX_WIDTH: begin
          width_r <= clamp_dim(cfg_bus.data, emboss_pkg::MAX_WIDTH);
        end
        emboss_pkg::CFG_IDX_HEIGHT: begin
          height_r <= clamp_dim(cfg_bus.data, emboss_pkg::MAX_HEIGHT);
        end
        default: begin
        end
      endcase
    end
  end

  // Input side: position counters and line-store read.
  assign occupancy       = {1'b0, fifo_level} + {{emboss_pkg::FIFO_LVL_W{1'b0}}, s1_valid_r};
  assign in_stream.ready = (occupancy < (emboss_pkg::FIFO_LVL_W+1)'(emboss_pkg::FIFO_DEPTH));
  assign in_xfer         = in_stream.valid && in_stream.ready;

  assign col_cur  = in_stream.frame_start ? '0 : col_r;
  assign row_cur  = in_stream.frame_start ? '0 : row_r;
  assign col_inc  = DW'(col_cur) + 1'b1;
  assign row_inc  = DW'(row_cur) + 1'b1;
  assign col_wrap = (col_inc >= width_r);

  always_comb begin
    col_nxt = col_inc[CW-1:0];
    row_nxt = row_cur;
    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = (row_inc >= height_r) ? '0 : row_inc[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
      if (in_xfer) begin
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        s1_fwd_r <= s1_valid_r && (s1_addr_r == col_cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_px_r      <= in_stream.pixel;
      s1_addr_r    <= col_cur;
      s1_emit_r    <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
      s1_row_r     <= row_cur - 1'b1;
      s1_col_r     <= col_cur - 1'b1;
      s1_last_r    <= (DW'(row_cur) == height_r - 1'b1) && (DW'(col_cur) == width_r - 1'b1);
      fwd_upper_r  <= s1_mid;
      fwd_middle_r <= s1_px_r;
    end
  end

  // Line store: upper row in the high byte, middle row in the low byte.
  emboss_ram #(
    .WIDTH (2 * PW),
    .DEPTH (emboss_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata ({s1_mid, s1_px_r}),
    .re    (in_xfer),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  // A write still in flight to the same column is taken from the bypass.
  assign s1_top = s1_fwd_r ? fwd_upper_r  : ram_rdata[2*PW-1:PW];
  assign s1_mid = s1_fwd_r ? fwd_middle_r : ram_rdata[PW-1:0];

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      w00_r <= w01_r;
      w01_r <= s1_top;
      w10_r <= w11_r;
      w11_r <= s1_mid;
      w21_r <= s1_px_r;
    end
  end

  always_comb begin
    sum = SW'(emboss_pkg::BIAS)
        - $signed({3'b000, w00_r, 1'b0})
        - $signed({4'b0000, w01_r})
        - $signed({4'b0000, w10_r})
        + $signed({4'b0000, w11_r})
        + $signed({4'b0000, s1_mid})
        + $signed({4'b0000, w21_r})
        + $signed({3'b000, s1_px_r, 1'b0});
    if (sum < 0) begin
      value = '0;
    end else if (sum > SW'(emboss_pkg::PIX_MAX)) begin
      value = PW'(emboss_pkg::PIX_MAX);
    end else begin
      value = sum[PW-1:0];
    end
  end

  assign fifo_push.push       = s1_valid_r && s1_emit_r;
  assign fifo_push.data.value = value;
  assign fifo_push.data.row   = s1_row_r;
  assign fifo_push.data.col   = s1_col_r;
  assign fifo_push.data.last  = s1_last_r;

  emboss_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fifo_push),
    .level      (fifo_level),
    .out_stream (out_stream)
  );

endmodule

[hw/rtl/emboss_chk.sv]
// ----------------------------------------------------------------------------
// emboss_chk
// Port-level checks on the emboss filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module emboss_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [emboss_pkg::PIX_W-1:0]  out_value,
  input logic [emboss_pkg::ROW_W-1:0]  out_row,
  input logic [emboss_pkg::COL_W-1:0]  out_col
);

  // A pending result is held until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_row)
      && $stable(out_col))
    else $error("result changed before its transfer");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A result first appears only after an input transfer.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input transfer");

  // Pixels of the first row and the first column are never emitted.
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row != '0) && (out_col != '0))
    else $error("border pixel emitted");

endmodule

bind emboss_3x3_filter emboss_chk u_emboss_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_stream.valid),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_value (out_stream.value),
  .out_row   (out_stream.out_row),
  .out_col   (out_stream.out_col)
);
